// ===== rtl/point_cloud_bilateral_filter_top_macros.svh =====
// assertion macros for the bilateral filter rtl
`ifndef POINT_CLOUD_BILATERAL_FILTER_TOP_MACROS_SVH
`define POINT_CLOUD_BILATERAL_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define PCBF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcbf same-cycle check failed");

// next-cycle implication
`define PCBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcbf next-cycle check failed");

`endif

// ===== rtl/pcbf_pkg.sv =====
// shared types and constants of the bilateral point filter
package pcbf_pkg;

	localparam int POS_W    = 32;
	localparam int NORM_W   = 16;
	localparam int CFG_W    = 32;
	localparam int ARG_BITS = 20;

	localparam logic CFG_RANGE_SCALE   = 1'b0;
	localparam logic CFG_FEATURE_SCALE = 1'b1;

	localparam logic [CFG_W-1:0] RANGE_SCALE_RST   = 32'd839;
	localparam logic [CFG_W-1:0] FEATURE_SCALE_RST = 32'd838860800;

	typedef enum logic [1:0] {
		KIND_CENTRE,
		KIND_NEIGH,
		KIND_CLOSE
	} pcbf_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OFF,
		ST_SQ,
		ST_FEAT,
		ST_ARG,
		ST_LOOK,
		ST_ACC,
		ST_FIN,
		ST_DIV,
		ST_MOVE,
		ST_OUT
	} pcbf_state_t;

	typedef struct packed {
		pcbf_kind_t               kind;
		logic                     last;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic [POS_W-1:0]         sq_distance;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
	} pcbf_item_t;

	typedef struct packed {
		logic       valid;
		pcbf_item_t item;
	} pcbf_head_t;

	typedef struct packed {
		logic [CFG_W-1:0] range_scale;
		logic [CFG_W-1:0] feature_scale;
	} pcbf_cfg_t;

endpackage

// ===== rtl/pcbf_front.sv =====
// front end: classifies incoming points and queues them for the datapath
module pcbf_front #(
	parameter int MAX_NEIGHBOURS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pcbf_pkg::POS_W-1:0]    pos_x,
	input  logic signed [pcbf_pkg::POS_W-1:0]    pos_y,
	input  logic signed [pcbf_pkg::POS_W-1:0]    pos_z,
	input  logic [pcbf_pkg::POS_W-1:0]           sq_distance,
	input  logic signed [pcbf_pkg::NORM_W-1:0]   norm_x,
	input  logic signed [pcbf_pkg::NORM_W-1:0]   norm_y,
	input  logic signed [pcbf_pkg::NORM_W-1:0]   norm_z,
	input  logic                                 is_centre,
	input  logic                                 last_point,
	output logic                                 busy,
	output pcbf_pkg::pcbf_head_t                 head,
	input  logic                                 pop
);

	localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);

	logic                 have_centre_q;
	logic [CNT_W-1:0]     count_q;
	pcbf_pkg::pcbf_item_t q_mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 accept;
	logic                 push;
	pcbf_pkg::pcbf_kind_t kind;

	assign busy   = (fill_q == 2'd2);
	assign accept = start & ~busy;

	always_comb begin
		push = 1'b0;
		kind = pcbf_pkg::KIND_NEIGH;
		if (accept) begin
			if (is_centre) begin
				push = 1'b1;
				kind = pcbf_pkg::KIND_CENTRE;
			end else if (have_centre_q) begin
				if (count_q < CNT_W'(MAX_NEIGHBOURS)) begin
					push = 1'b1;
					kind = pcbf_pkg::KIND_NEIGH;
				end else if (last_point) begin
					// neighbour beyond the limit only closes the group
					push = 1'b1;
					kind = pcbf_pkg::KIND_CLOSE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_centre_q <= 1'b0;
			count_q       <= '0;
			wr_ptr_q      <= 1'b0;
			rd_ptr_q      <= 1'b0;
			fill_q        <= 2'd0;
		end else begin
			if (accept) begin
				if (is_centre) begin
					have_centre_q <= ~last_point;
					count_q       <= '0;
				end else if (have_centre_q) begin
					if (count_q < CNT_W'(MAX_NEIGHBOURS)) begin
						count_q <= count_q + 1'b1;
					end
					if (last_point) begin
						have_centre_q <= 1'b0;
					end
				end
			end
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{
				kind:        kind,
				last:        last_point,
				pos_x:       pos_x,
				pos_y:       pos_y,
				pos_z:       pos_z,
				sq_distance: sq_distance,
				norm_x:      norm_x,
				norm_y:      norm_y,
				norm_z:      norm_z
			};
		end
	end

	assign head.valid = (fill_q != 2'd0);
	assign head.item  = q_mem_q[rd_ptr_q];

endmodule

// ===== rtl/pcbf_back.sv =====
// back end: weights neighbours, accumulates and moves the centre along its normal
module pcbf_back #(
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int MAX_NEIGHBOURS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pcbf_pkg::pcbf_head_t               head,
	output logic                               pop,
	input  pcbf_pkg::pcbf_cfg_t                cfg,
	output logic                               done,
	output logic signed [pcbf_pkg::POS_W-1:0]  new_x,
	output logic signed [pcbf_pkg::POS_W-1:0]  new_y,
	output logic signed [pcbf_pkg::POS_W-1:0]  new_z,
	output logic                               zero_weight
);

	localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
	localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
	localparam int WS_W    = 17 + CNT_W;
	localparam int WOS_W   = 49 + CNT_W;
	localparam int DCNT_W  = $clog2(WOS_W + 1);
	localparam int SC_W    = pcbf_pkg::ARG_BITS + IDX_W;
	localparam int AB      = pcbf_pkg::ARG_BITS;

	localparam longint unsigned EXP_X = (64'd1 << 36) / EXP_TABLE_DEPTH;

	typedef logic [16:0] exp_tbl_t [EXP_TABLE_DEPTH];

	// long division used only while the table is built
	function automatic longint unsigned udiv64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned rm;
		q  = '0;
		rm = '0;
		for (int b = 63; b >= 0; b--) begin
			rm = {rm[62:0], n[b]};
			if (rm >= d) begin
				rm   = rm - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic exp_tbl_t build_exp_tbl();
		longint unsigned term;
		longint unsigned r;
		longint unsigned v;
		exp_tbl_t        t;
		term = 64'd1 << 32;
		r    = term;
		v    = 64'd1 << 32;
		// series for exp(-16/depth) in Q.32
		for (int kk = 1; kk < 64; kk++) begin
			if (term != 0) begin
				term = udiv64((term * EXP_X) >> 32, 64'(kk));
				if (kk[0]) r = r - term;
				else r = r + term;
			end
		end
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			t[i] = 17'((v + 64'h8000) >> 16);
			v    = (v * r + 64'h80000000) >> 32;
		end
		return t;
	endfunction

	localparam exp_tbl_t EXP_TBL = build_exp_tbl();

	function automatic logic signed [31:0] sat32(input logic signed [50:0] a);
		logic signed [31:0] res;
		if (a > 51'sd2147483647) res = 32'sh7FFFFFFF;
		else if (a < -51'sd2147483648) res = 32'sh80000000;
		else res = a[31:0];
		return res;
	endfunction

	pcbf_pkg::pcbf_state_t state_q, state_d;

	logic signed [31:0]       cpos_q [3];
	logic signed [15:0]       cnorm_q [3];
	logic signed [48:0]       prod_q [3];
	logic [63:0]              rprod_q;
	logic                     last_q;
	logic signed [31:0]       off_q;
	logic [20:0]              ar_q;
	logic [47:0]              sq16_q;
	logic                     big_q;
	logic [63:0]              pp_lo_q;
	logic [43:0]              pp_hi_q;
	logic                     wz_q;
	logic [IDX_W-1:0]         idx_q;
	logic [16:0]              w_q;
	logic signed [WOS_W-1:0]  wos_q;
	logic [WS_W-1:0]          ws_q;
	logic                     neg_q;
	logic [WOS_W-1:0]         quo_q;
	logic [WS_W-1:0]          rem_q;
	logic [DCNT_W-1:0]        div_cnt_q;
	logic signed [48:0]       mvp_q [3];
	logic                     done_q;

	logic signed [32:0]       diff [3];
	logic signed [50:0]       dot;
	logic signed [50:0]       rnd;
	logic [31:0]              mag;
	logic [63:0]              sq_full;
	logic [75:0]              pp;
	logic [51:0]              sh;
	logic [20:0]              af;
	logic [21:0]              total;
	logic [SC_W-1:0]          scaled;
	logic signed [48:0]       wprod;
	logic [WOS_W-1:0]         wmag;
	logic [WS_W:0]            trial;
	logic                     ge;
	logic signed [32:0]       qs;
	logic signed [32:0]       shift;
	logic signed [48:0]       mvr [3];
	logic signed [49:0]       nsum [3];
	pcbf_pkg::pcbf_item_t     it;

	assign it = head.item;

	always_comb begin
		diff[0] = 33'(cpos_q[0]) - 33'(it.pos_x);
		diff[1] = 33'(cpos_q[1]) - 33'(it.pos_y);
		diff[2] = 33'(cpos_q[2]) - 33'(it.pos_z);
		dot     = 51'(prod_q[0]) + 51'(prod_q[1]) + 51'(prod_q[2]);
		rnd     = (dot + 51'sd8192) >>> 14;
		mag     = off_q[31] ? 32'(-off_q) : 32'(off_q);
		sq_full = 64'(mag) * 64'(mag);
		pp      = {pp_hi_q, 32'd0} + {12'd0, pp_lo_q};
		sh      = pp[75:24];
		if (cfg.feature_scale == '0) af = '0;
		else if (big_q || sh > 52'(1 << AB)) af = 21'(1 << AB);
		else af = sh[20:0];
		total   = {1'b0, ar_q} + {1'b0, af};
		scaled  = SC_W'(total[AB-1:0]) * SC_W'(EXP_TABLE_DEPTH);
		wprod   = 49'(signed'({1'b0, w_q})) * 49'(off_q);
		wmag    = wos_q[WOS_W-1] ? WOS_W'(-wos_q) : WOS_W'(wos_q);
		trial   = {rem_q, quo_q[WOS_W-1]};
		ge      = (trial >= {1'b0, ws_q});
		qs      = signed'(quo_q[32:0]);
		shift   = neg_q ? qs : -qs;
		for (int i = 0; i < 3; i++) begin
			mvr[i]  = (mvp_q[i] + 49'sd8192) >>> 14;
			nsum[i] = 50'(cpos_q[i]) + 50'(mvr[i]);
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			pcbf_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (it.kind)
						pcbf_pkg::KIND_CENTRE:
							state_d = it.last ? pcbf_pkg::ST_FIN : pcbf_pkg::ST_IDLE;
						pcbf_pkg::KIND_NEIGH:  state_d = pcbf_pkg::ST_OFF;
						pcbf_pkg::KIND_CLOSE:  state_d = pcbf_pkg::ST_FIN;
						default:               state_d = pcbf_pkg::ST_IDLE;
					endcase
				end
			end
			pcbf_pkg::ST_OFF:  state_d = pcbf_pkg::ST_SQ;
			pcbf_pkg::ST_SQ:   state_d = pcbf_pkg::ST_FEAT;
			pcbf_pkg::ST_FEAT: state_d = pcbf_pkg::ST_ARG;
			pcbf_pkg::ST_ARG:  state_d = pcbf_pkg::ST_LOOK;
			pcbf_pkg::ST_LOOK: state_d = pcbf_pkg::ST_ACC;
			pcbf_pkg::ST_ACC:  state_d = last_q ? pcbf_pkg::ST_FIN : pcbf_pkg::ST_IDLE;
			pcbf_pkg::ST_FIN:
				state_d = (ws_q == '0) ? pcbf_pkg::ST_IDLE : pcbf_pkg::ST_DIV;
			pcbf_pkg::ST_DIV:
				state_d = (div_cnt_q == DCNT_W'(1)) ? pcbf_pkg::ST_MOVE : pcbf_pkg::ST_DIV;
			pcbf_pkg::ST_MOVE: state_d = pcbf_pkg::ST_OUT;
			pcbf_pkg::ST_OUT:  state_d = pcbf_pkg::ST_IDLE;
			default:           state_d = pcbf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcbf_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == pcbf_pkg::ST_OUT) ||
				((state_q == pcbf_pkg::ST_FIN) && (ws_q == '0));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcbf_pkg::ST_IDLE: begin
				if (head.valid) begin
					last_q <= it.last;
					if (it.kind == pcbf_pkg::KIND_CENTRE) begin
						cpos_q[0]  <= it.pos_x;
						cpos_q[1]  <= it.pos_y;
						cpos_q[2]  <= it.pos_z;
						cnorm_q[0] <= it.norm_x;
						cnorm_q[1] <= it.norm_y;
						cnorm_q[2] <= it.norm_z;
						wos_q      <= '0;
						ws_q       <= '0;
					end else begin
						prod_q[0] <= 49'(diff[0]) * 49'(cnorm_q[0]);
						prod_q[1] <= 49'(diff[1]) * 49'(cnorm_q[1]);
						prod_q[2] <= 49'(diff[2]) * 49'(cnorm_q[2]);
						rprod_q   <= 64'(it.sq_distance) * 64'(cfg.range_scale);
					end
				end
			end
			pcbf_pkg::ST_OFF: begin
				off_q <= sat32(rnd);
				ar_q  <= (rprod_q[63:24] > 40'(1 << AB)) ? 21'(1 << AB) : rprod_q[44:24];
			end
			pcbf_pkg::ST_SQ: begin
				sq16_q <= sq_full[63:16];
			end
			pcbf_pkg::ST_FEAT: begin
				// feature product split in two partial products
				big_q   <= |sq16_q[47:44];
				pp_lo_q <= 64'(sq16_q[31:0]) * 64'(cfg.feature_scale);
				pp_hi_q <= 44'(sq16_q[43:32]) * 44'(cfg.feature_scale);
			end
			pcbf_pkg::ST_ARG: begin
				wz_q  <= (total >= 22'(1 << AB));
				idx_q <= scaled[AB +: IDX_W];
			end
			pcbf_pkg::ST_LOOK: begin
				w_q <= wz_q ? 17'd0 : EXP_TBL[idx_q];
			end
			pcbf_pkg::ST_ACC: begin
				wos_q <= wos_q + WOS_W'(wprod);
				ws_q  <= ws_q + WS_W'(w_q);
			end
			pcbf_pkg::ST_FIN: begin
				if (ws_q == '0) begin
					new_x       <= cpos_q[0];
					new_y       <= cpos_q[1];
					new_z       <= cpos_q[2];
					zero_weight <= 1'b1;
				end else begin
					neg_q     <= wos_q[WOS_W-1];
					quo_q     <= wmag;
					rem_q     <= '0;
					div_cnt_q <= DCNT_W'(WOS_W);
				end
			end
			pcbf_pkg::ST_DIV: begin
				// restoring divide, one quotient bit a cycle
				rem_q     <= ge ? WS_W'(trial - {1'b0, ws_q}) : WS_W'(trial);
				quo_q     <= {quo_q[WOS_W-2:0], ge};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			pcbf_pkg::ST_MOVE: begin
				for (int i = 0; i < 3; i++) begin
					mvp_q[i] <= 49'(shift) * 49'(cnorm_q[i]);
				end
			end
			pcbf_pkg::ST_OUT: begin
				new_x       <= sat32(51'(nsum[0]));
				new_y       <= sat32(51'(nsum[1]));
				new_z       <= sat32(51'(nsum[2]));
				zero_weight <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;

endmodule

// ===== rtl/point_cloud_bilateral_filter_top.sv =====
// top level of the bilateral point filter: config registers, front and back
// datapath: a neighbour passes states OFF, SQ, FEAT, ARG, LOOK and ACC; the last
// request of a group then runs FIN and, for a non-zero weight sum, the bit-serial
// weight divider (DIV), MOVE and OUT; a two-entry queue absorbs requests while
// the datapath works on one at a time; busy is high when the queue is full.
// reset: arst_n clears control, queue and config registers (to their defaults).
`include "point_cloud_bilateral_filter_top_macros.svh"

module point_cloud_bilateral_filter_top #(
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int MAX_NEIGHBOURS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [pcbf_pkg::POS_W-1:0]   pos_x,
	input  logic signed [pcbf_pkg::POS_W-1:0]   pos_y,
	input  logic signed [pcbf_pkg::POS_W-1:0]   pos_z,
	input  logic [pcbf_pkg::POS_W-1:0]          sq_distance,
	input  logic signed [pcbf_pkg::NORM_W-1:0]  norm_x,
	input  logic signed [pcbf_pkg::NORM_W-1:0]  norm_y,
	input  logic signed [pcbf_pkg::NORM_W-1:0]  norm_z,
	input  logic                                is_centre,
	input  logic                                last_point,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [pcbf_pkg::CFG_W-1:0]          cfg_data,
	output logic                                done,
	output logic signed [pcbf_pkg::POS_W-1:0]   new_x,
	output logic signed [pcbf_pkg::POS_W-1:0]   new_y,
	output logic signed [pcbf_pkg::POS_W-1:0]   new_z,
	output logic                                zero_weight
);

	pcbf_pkg::pcbf_cfg_t  cfg_q;
	pcbf_pkg::pcbf_head_t head;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_scale   <= pcbf_pkg::RANGE_SCALE_RST;
			cfg_q.feature_scale <= pcbf_pkg::FEATURE_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcbf_pkg::CFG_RANGE_SCALE:   cfg_q.range_scale   <= cfg_data;
				pcbf_pkg::CFG_FEATURE_SCALE: cfg_q.feature_scale <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pcbf_front #(
		.MAX_NEIGHBOURS(MAX_NEIGHBOURS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.sq_distance (sq_distance),
		.norm_x      (norm_x),
		.norm_y      (norm_y),
		.norm_z      (norm_z),
		.is_centre   (is_centre),
		.last_point  (last_point),
		.busy        (busy),
		.head        (head),
		.pop         (pop)
	);

	pcbf_back #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.cfg         (cfg_q),
		.done        (done),
		.new_x       (new_x),
		.new_y       (new_y),
		.new_z       (new_z),
		.zero_weight (zero_weight)
	);

	// the datapath never pops an empty queue
	`PCBF_ASSERT_SAME(a_pop_has_head, clk, arst_n, pop, head.valid)
	// a full queue always offers a request
	`PCBF_ASSERT_SAME(a_busy_has_head, clk, arst_n, busy, head.valid)
	// results are single-cycle strobes, never back to back
	`PCBF_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

endmodule

// ===== verif/point_cloud_bilateral_filter_top_tb.sv =====
// testbench of the bilateral point filter: streams neighborhoods and checks each filtered point
`timescale 1ns / 100ps

module point_cloud_bilateral_filter_top_tb;

	localparam int TABLE_DEPTH = 256;
	localparam int NEIGH_MAX   = 32;
	localparam longint unsigned ARG_CAP = 64'd16 << 16;
	localparam int SETTLE_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [31:0]        d2;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               centre;
		logic               last;
	} point_req_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               zw;
	} point_res_t;

	class filter_scoreboard;
		logic [31:0] rng_scale;
		logic [31:0] feat_scale;
		longint unsigned exp_lut[TABLE_DEPTH];
		longint cpos[3];
		longint cnorm[3];
		longint off_acc;
		longint w_acc;
		bit open;
		int unsigned ncount;
		point_res_t pending[$];
		int unsigned mismatches;

		function new();
			longint unsigned x, term, r, k, v;
			x = (64'd1 << 36) / TABLE_DEPTH;
			term = 64'd1 << 32;
			r = term;
			k = 1;
			while (term != 0 && k < 64) begin
				term = ((term * x) >> 32) / k;
				if (k[0]) r -= term; else r += term;
				k++;
			end
			v = 64'd1 << 32;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				exp_lut[i] = (v + 64'h8000) >> 16;
				v = (v * r + 64'h8000_0000) >> 32;
			end
			rng_scale = pcbf_pkg::RANGE_SCALE_RST;
			feat_scale = pcbf_pkg::FEATURE_SCALE_RST;
			open = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == pcbf_pkg::CFG_RANGE_SCALE) rng_scale = val;
			else feat_scale = val;
		endfunction

		// floor division by 2^14 after adding half
		function longint q30_to_q16(longint v);
			return (v + 64'sd8192) >>> 14;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint weight(longint unsigned d2, longint off);
			longint unsigned a_r, mag, sq, a_f, tot;
			logic [127:0] prod;
			a_r = (d2 * longint'(rng_scale)) >> 24;
			mag = off < 0 ? -off : off;
			sq = (mag * mag) >> 16;
			prod = {64'd0, sq} * {96'd0, feat_scale};
			if (prod[127:64] != 0) a_f = ARG_CAP;
			else a_f = prod[63:0] >> 24;
			if (a_r > ARG_CAP) a_r = ARG_CAP;
			if (a_f > ARG_CAP) a_f = ARG_CAP;
			tot = a_r + a_f;
			if (tot >= ARG_CAP) return 0;
			return longint'(exp_lut[(tot * TABLE_DEPTH) >> 20]);
		endfunction

		function void note_request(point_req_t q);
			longint p[3];
			longint dot, off, w, shift;
			point_res_t res;
			p[0] = q.px; p[1] = q.py; p[2] = q.pz;
			if (q.centre) begin
				cpos = p;
				cnorm[0] = q.nx; cnorm[1] = q.ny; cnorm[2] = q.nz;
				off_acc = 0;
				w_acc = 0;
				ncount = 0;
				open = 1;
			end else begin
				if (!open) return;
				if (ncount < NEIGH_MAX) begin
					dot = 0;
					for (int i = 0; i < 3; i++) dot += (cpos[i] - p[i]) * cnorm[i];
					off = clamp32(q30_to_q16(dot));
					w = weight(q.d2, off);
					off_acc += w * off;
					w_acc += w;
					ncount++;
				end
			end
			if (!q.last) return;
			open = 0;
			if (w_acc == 0) begin
				res = {cpos[0][31:0], cpos[1][31:0], cpos[2][31:0], 1'b1};
			end else begin
				shift = -(off_acc / w_acc);
				for (int i = 0; i < 3; i++) p[i] = clamp32(cpos[i] + q30_to_q16(shift * cnorm[i]));
				res = {p[0][31:0], p[1][31:0], p[2][31:0], 1'b0};
			end
			pending = {pending, res};
		endfunction

		function void check_result(point_res_t got);
			point_res_t want;
			if (pending.size() == 0) begin
				if (mismatches < 10) $display("unexpected point %h %h %h zw=%b",
					got.x, got.y, got.z, got.zw);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got != want) begin
				if (mismatches < 10)
					$display("mismatch: want %h %h %h zw=%b, got %h %h %h zw=%b",
						want.x, want.y, want.z, want.zw, got.x, got.y, got.z, got.zw);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic [31:0] sq_distance = 0;
	logic signed [15:0] norm_x = 0, norm_y = 0, norm_z = 0;
	logic is_centre = 0, last_point = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic done;
	logic signed [31:0] new_x, new_y, new_z;
	logic zero_weight;

	filter_scoreboard sb = new();
	int idle_pct;
	int sent;
	longint cycles;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	point_cloud_bilateral_filter_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .sq_distance(sq_distance),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.is_centre(is_centre), .last_point(last_point),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .new_x(new_x), .new_y(new_y), .new_z(new_z),
		.zero_weight(zero_weight)
	);

	always @(posedge clk) begin
		cycles++;
		if (arst_n && done) sb.check_result({new_x, new_y, new_z, zero_weight});
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send(point_req_t q);
		int gap;
		start <= 1;
		pos_x <= q.px; pos_y <= q.py; pos_z <= q.pz; sq_distance <= q.d2;
		norm_x <= q.nx; norm_y <= q.ny; norm_z <= q.nz;
		is_centre <= q.centre; last_point <= q.last;
		do @(posedge clk); while (busy);
		sb.note_request(q);
		sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every filtered point is back and the datapath is quiet
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic signed [15:0] rand_norm();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic point_req_t rand_centre(bit last);
		point_req_t q;
		q.px = $urandom; q.py = $urandom; q.pz = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			q.px = q.px >>> 8; q.py = q.py >>> 8; q.pz = q.pz >>> 8;
		end
		q.d2 = $urandom;
		q.nx = rand_norm(); q.ny = rand_norm(); q.nz = rand_norm();
		q.centre = 1;
		q.last = last;
		return q;
	endfunction

	function automatic point_req_t rand_neigh(point_req_t c, bit last);
		point_req_t q;
		int sh;
		q = c;
		sh = $urandom_range(0, 6);
		if ($urandom_range(0, 9) == 0) begin
			q.px = $urandom; q.py = $urandom; q.pz = $urandom;
		end else begin
			q.px = c.px + (($signed(32'($urandom_range(0, 65535))) - 32768) >>> sh);
			q.py = c.py + (($signed(32'($urandom_range(0, 65535))) - 32768) >>> sh);
			q.pz = c.pz + (($signed(32'($urandom_range(0, 65535))) - 32768) >>> sh);
		end
		q.d2 = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22);
		q.nx = 16'($urandom); q.ny = 16'($urandom); q.nz = 16'($urandom);
		q.centre = 0;
		q.last = last;
		return q;
	endfunction

	task automatic neighborhood(int nn);
		point_req_t c;
		c = rand_centre(nn == 0);
		send(c);
		for (int i = 1; i <= nn; i++) send(rand_neigh(c, i == nn));
	endtask

	task automatic directed();
		point_req_t c, n;
		// stray neighbour closing with no centre open
		n = rand_neigh(rand_centre(0), 1);
		send(n);
		// lone centre at the top of the range
		c = {32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hFFFFFFFF,
			16'sd16384, 16'sd16384, 16'sd16384, 1'b1, 1'b1};
		send(c);
		// bottom of the range, negative normal, max distance neighbour
		c = {32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h0,
			-16'sd16384, -16'sd16384, -16'sd16384, 1'b1, 1'b0};
		send(c);
		n = c; n.centre = 0; n.d2 = 0;
		send(n);
		n.px = c.px + 32'sh2000; n.d2 = 32'hFFFFFFFF;
		send(n);
		n.d2 = 32'h100; n.last = 1;
		send(n);
		// neighbour x wraps past the top of the range, so the group gets zero weight
		c = {32'sh7FFFF000, 32'sh0, 32'sh0, 32'h0, 16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b0};
		send(c);
		n = c; n.centre = 0; n.px = c.px + 32'sh4000; n.d2 = 32'h10; n.last = 1;
		send(n);
		// new centre drops the open neighborhood
		c = rand_centre(0);
		send(c);
		send(rand_neigh(c, 0));
		c = rand_centre(0);
		send(c);
		send(rand_neigh(c, 1));
		// odd normal (FFFF, 0, 7FFF) on a neighbour, must be ignored
		c = rand_centre(0);
		send(c);
		n = rand_neigh(c, 1); n.nx = 16'hFFFF; n.ny = 16'h0; n.nz = 16'h7FFF;
		send(n);
	endtask

	task automatic random_phase(int items);
		int r, goal;
		point_req_t c;
		goal = sent + items;
		while (sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 70) neighborhood($urandom_range(1, 8));
			else if (r < 76) neighborhood($urandom_range(30, 40));
			else if (r < 84) neighborhood(0);
			else if (r < 92) send(rand_neigh(rand_centre(0), 1'($urandom_range(0, 1))));
			else begin
				c = rand_centre(0);
				send(c);
				repeat ($urandom_range(1, 3)) send(rand_neigh(c, 0));
			end
		end
	endtask

	initial begin
		logic [31:0] rs[5];
		logic [31:0] fs[5];
		rs = '{pcbf_pkg::RANGE_SCALE_RST, 32'h0, 32'hFFFFFFFF, 32'h0000_0400, 32'h0};
		fs = '{pcbf_pkg::FEATURE_SCALE_RST, 32'h0, 32'hFFFFFFFF, 32'h0100_0000, 32'h0};
		rs[4] = $urandom;
		fs[4] = $urandom;
		cycles = 0;
		sent = 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_reg(pcbf_pkg::CFG_RANGE_SCALE, rs[ph]);
			write_reg(pcbf_pkg::CFG_FEATURE_SCALE, fs[ph]);
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 62;
				2: idle_pct = 0;
				default: idle_pct = 31;
			endcase
			random_phase(276);
		end
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pcbf_pkg.sv
rtl/pcbf_front.sv
rtl/pcbf_back.sv
rtl/point_cloud_bilateral_filter_top.sv
verif/point_cloud_bilateral_filter_top_tb.sv
